### sv/rlen_pkg.sv
// Shared types and constants for the run-length encoder with null handling.
package rlen_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned COUNT_W     = 17;
  localparam int unsigned COUNT_MAX   = 131071;
  localparam int unsigned IN_TDATA_W  = 32;
  localparam int unsigned OUT_TDATA_W = 56;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int unsigned FILL_W      = $clog2(QUEUE_DEPTH + 1);

  // One finished run waiting to be delivered.
  typedef struct packed {
    logic [COUNT_W-1:0] run_length;
    logic [DATA_W-1:0]  run_value;
    logic               final_run;
  } run_t;

  // What the front hands the queue in one cycle: zero, one or two runs,
  // with the earlier one always in slot a.
  typedef struct packed {
    logic [1:0] num;
    run_t       run_a;
    run_t       run_b;
  } push_t;

endpackage

### sv/rlen_front.sv
// Front end: accepts column elements, tracks the open run and classifies each element.
module rlen_front #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned MAX_COLUMN  = 65536
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic [rlen_pkg::DATA_W-1:0] in_value_i,
  input  logic                     in_present_i,
  input  logic                     in_last_i,
  input  logic                     space_i,
  output logic                     in_ready_o,
  output rlen_pkg::push_t          push_o
);

  localparam int unsigned CMP_W =
    (VALUE_WIDTH > rlen_pkg::DATA_W) ? rlen_pkg::DATA_W : VALUE_WIDTH;
  localparam logic [rlen_pkg::COUNT_W-1:0] LIMIT = rlen_pkg::COUNT_W'(
    (MAX_COLUMN > rlen_pkg::COUNT_MAX) ? rlen_pkg::COUNT_MAX : MAX_COLUMN);

  logic [CMP_W-1:0]            val_q, val_d;
  logic [rlen_pkg::COUNT_W-1:0] cnt_q, cnt_d;
  logic                        in_col_q, in_col_d;

  logic                        accept;
  logic [CMP_W-1:0]            v;
  logic                        emit_closed;
  logic [rlen_pkg::DATA_W-1:0] old_val_ext;
  logic [rlen_pkg::DATA_W-1:0] new_val_ext;
  rlen_pkg::run_t              closed_run;
  rlen_pkg::run_t              final_run;

  assign in_ready_o = space_i;
  assign accept     = in_valid_i & space_i;
  assign v          = in_value_i[CMP_W-1:0];

  always_comb begin
    val_d       = val_q;
    cnt_d       = cnt_q;
    in_col_d    = in_col_q;
    emit_closed = 1'b0;
    old_val_ext = '0;
    old_val_ext[CMP_W-1:0] = val_q;
    if (accept) begin
      if (!in_col_q) begin
        val_d    = v;
        cnt_d    = rlen_pkg::COUNT_W'(1);
        in_col_d = 1'b1;
      end else if ((v == val_q) || !in_present_i) begin
        if (cnt_q >= LIMIT) begin
          emit_closed = 1'b1;
          cnt_d       = rlen_pkg::COUNT_W'(1);
        end else begin
          cnt_d = cnt_q + rlen_pkg::COUNT_W'(1);
        end
      end else begin
        emit_closed = 1'b1;
        val_d       = v;
        cnt_d       = rlen_pkg::COUNT_W'(1);
      end
    end
    new_val_ext = '0;
    new_val_ext[CMP_W-1:0] = val_d;

    closed_run.run_length = cnt_q;
    closed_run.run_value  = old_val_ext;
    closed_run.final_run  = 1'b0;
    final_run.run_length  = cnt_d;
    final_run.run_value   = new_val_ext;
    final_run.final_run   = 1'b1;

    push_o.run_a = emit_closed ? closed_run : final_run;
    push_o.run_b = final_run;
    push_o.num   = 2'd0;
    if (accept) begin
      push_o.num = {1'b0, emit_closed} + {1'b0, in_last_i};
    end

    // The column closes after its last element.
    if (accept && in_last_i) begin
      in_col_d = 1'b0;
      cnt_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      in_col_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      in_col_q <= in_col_d;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

`ifndef NO_ASSERTIONS
  a_last_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_last_i |=> !in_col_q && (cnt_q == '0))
    else $error("column still open after its last element");
  a_open_has_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_col_q |-> (cnt_q != '0) && (cnt_q <= LIMIT))
    else $error("open run with a count outside 1..limit");
`endif

endmodule

### sv/rlen_queue.sv
// Short queue between front and back; takes up to two runs per cycle, gives one.
module rlen_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  rlen_pkg::push_t push_i,
  output logic            space_o,
  input  logic            pop_i,
  output logic            head_valid_o,
  output rlen_pkg::run_t  head_o
);

  rlen_pkg::run_t              mem_q [rlen_pkg::QUEUE_DEPTH];
  logic [rlen_pkg::PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [rlen_pkg::PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [rlen_pkg::FILL_W-1:0] fill_q, fill_d;
  logic [rlen_pkg::PTR_W-1:0]  wr_ptr_nxt;

  // Room for two runs is required so a last element can always be taken.
  assign space_o      = fill_q <= rlen_pkg::FILL_W'(rlen_pkg::QUEUE_DEPTH - 2);
  assign head_valid_o = fill_q != '0;
  assign head_o       = mem_q[rd_ptr_q];
  assign wr_ptr_nxt   = wr_ptr_q + rlen_pkg::PTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + rlen_pkg::PTR_W'(push_i.num);
    rd_ptr_d = rd_ptr_q + rlen_pkg::PTR_W'(pop_i);
    fill_d   = fill_q + rlen_pkg::FILL_W'(push_i.num) - rlen_pkg::FILL_W'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.run_a;
    end
    if (push_i.num == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.run_b;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i.num != 2'd0) |-> space_o)
    else $error("runs pushed into a queue without room");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> head_valid_o)
    else $error("pop from an empty queue");
`endif

endmodule

### sv/rlen_back.sv
// Back end: output register that delivers queued runs on the master stream.
module rlen_back (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             head_valid_i,
  input  rlen_pkg::run_t                   head_i,
  output logic                             pop_o,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rlen_pkg::OUT_TDATA_W-1:0] out_data_o,
  output logic                             out_last_o
);

  logic                             valid_q;
  logic [rlen_pkg::OUT_TDATA_W-1:0] data_q, data_d;
  logic                             last_q;
  logic                             load;

  assign load  = !valid_q || out_ready_i;
  assign pop_o = head_valid_i && load;

  always_comb begin
    data_d = '0;
    data_d[rlen_pkg::COUNT_W-1:0] = head_i.run_length;
    data_d[rlen_pkg::COUNT_W +: rlen_pkg::DATA_W] = head_i.run_value;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= head_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      data_q <= data_d;
      last_q <= head_i.final_run;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;
  assign out_last_o  = last_q;

endmodule

### sv/run_length_encoder_with_nulls_unit.sv
// Top level of the run-length encoder for columns that may contain nulls.
//
// Usage: column elements arrive on the slave stream, one per beat. tdata
// carries the value, tuser is the present flag (low means null) and tlast
// marks the final element of a column. Each element either extends the open
// run (equal value or null) or closes it; closed runs leave on the master
// stream as run length and run value, with tlast set on the final run.
// The first element of a column always opens the run, even when it is null.
// A run that reaches MAX_COLUMN elements (at most 131071) is closed and
// restarted. An accepted element's first run is queued and then registered
// in the back end before it reaches the master side. One element is taken
// every cycle while the master side keeps up; a last element that closes a
// run as well yields two runs in one cycle, and since the back end drains
// one run per cycle, the queue between front and back absorbs them. The
// slave side is ready while the four-entry queue has room for two runs, so a
// stalled receiver backs up the input and nothing is lost. Reset closes any
// open column and empties the queue; the next element starts a new column.
module run_length_encoder_with_nulls_unit #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned MAX_COLUMN  = 65536
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [rlen_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [31:0] value
  input  logic                             s_axis_tuser,  // [0] present
  input  logic                             s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [16:0] run_length, [48:17] run_value, [55:49] zero fill
  output logic [rlen_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  output logic                             m_axis_tlast   // final_run
);

  rlen_pkg::push_t push;
  logic            space;
  logic            pop;
  logic            head_valid;
  rlen_pkg::run_t  head;

  // Front end holds the open run and decides which runs each element closes.
  rlen_front #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_COLUMN  (MAX_COLUMN)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_value_i   (s_axis_tdata),
    .in_present_i (s_axis_tuser),
    .in_last_i    (s_axis_tlast),
    .space_i      (space),
    .in_ready_o   (s_axis_tready),
    .push_o       (push)
  );

  // The queue decouples the two sides so either one can stall.
  rlen_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .space_o      (space),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // The back end registers one run at a time for the receiver.
  rlen_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_data_o   (m_axis_tdata),
    .out_last_o   (m_axis_tlast)
  );

endmodule
